// ----- hdl/phr_pkg.sv -----
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types and constants for the packet header rewriter.
// ----------------------------------------------------------------------------
package phr_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAC_ENABLE  = 3'd0,
    CFG_DEST_MAC    = 3'd1,
    CFG_IP_ENABLE   = 3'd2,
    CFG_DEST_IP     = 3'd3,
    CFG_PORT_ENABLE = 3'd4,
    CFG_DEST_PORT   = 3'd5
  } cfg_index_t;

  localparam logic [15:0] DEST_PORT_RESET = 16'd8888;

  // protocol constants
  localparam logic [7:0]  ETHERTYPE_HI   = 8'h08;
  localparam logic [7:0]  ETHERTYPE_LO   = 8'h00;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  IHL_MASK       = 8'h0f;
  localparam int          IHL_SHIFT      = 2;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [11:0] IP_MIN_FRAME   = 12'd34;

  // live configuration
  typedef struct packed {
    logic        mac_replace_enable;
    logic [47:0] new_dest_mac;
    logic        ip_replace_enable;
    logic [31:0] new_dest_ip;
    logic        port_replace_enable;
    logic [15:0] new_dest_port;
  } phr_cfg_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       ip_cksum_request;
    logic       udp_cksum_request;
  } phr_result_t;

  // byte idx of the mac, first wire byte most significant
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

  // byte idx of a 32-bit word, most significant first
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/phr_in_if.sv -----
// ----------------------------------------------------------------------------
// phr_in_if
// Frame byte channel into the rewriter.
// ----------------------------------------------------------------------------
interface phr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic [11:0] frame_length;

  modport source (output valid, frame_byte, frame_end, frame_length, input ready);
  modport sink   (input valid, frame_byte, frame_end, frame_length, output ready);
endinterface

// ----- hdl/phr_out_if.sv -----
// ----------------------------------------------------------------------------
// phr_out_if
// Rewritten byte channel out of the rewriter.
// ----------------------------------------------------------------------------
interface phr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic       ip_cksum_request;
  logic       udp_cksum_request;

  modport source (output valid, out_byte, out_end, ip_cksum_request, udp_cksum_request,
                  input ready);
  modport sink   (input valid, out_byte, out_end, ip_cksum_request, udp_cksum_request,
                  output ready);
endinterface

// ----- hdl/packet_header_rewriter.sv -----
// ----------------------------------------------------------------------------
// packet_header_rewriter
// Ethernet / IPv4 / UDP destination rewrite on a byte stream.
// ----------------------------------------------------------------------------
// Frames enter on frame_in one byte per transfer, with frame_end on the last
// byte and frame_length repeated on every byte. Each byte gives exactly one
// transfer on frame_out, carrying the byte after any rewrite and the IPv4 and
// UDP checksum offload request flags.
// Configuration is written through cfg_write / cfg_index / cfg_data while no
// frame is in flight; index 0..5 follow the register list, others are ignored.
// Each result is registered in the output stage before it appears on frame_out.
// Throughput is one byte per cycle: the frame state registers and the short
// rewrite logic between them take a byte every cycle.
// When frame_out stalls, a skid stage takes one more byte, after which
// frame_in.ready drops until the receiver takes a result.
// Reset (rst, synchronous) clears frame state and flushes the output stage;
// configuration returns to its reset values (port 8888, all else zero).
// ----------------------------------------------------------------------------
module packet_header_rewriter #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  phr_in_if.sink                          frame_in,
  phr_out_if.source                       frame_out,
  input  logic                            cfg_write,
  input  logic [phr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [phr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import phr_pkg::*;

  phr_cfg_t    cfg;
  phr_result_t result;
  phr_result_t out_data;
  logic        push_ready;
  logic        accept;

  assign frame_in.ready = push_ready;
  assign accept         = frame_in.valid && push_ready;

  // configuration registers
  phr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // header tracking and rewrite
  phr_rewrite #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_rewrite (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_byte   (frame_in.frame_byte),
    .frame_end    (frame_in.frame_end),
    .frame_length (frame_in.frame_length),
    .cfg          (cfg),
    .result       (result)
  );

  // output register and skid stage
  phr_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .out_valid  (frame_out.valid),
    .out_ready  (frame_out.ready),
    .out_data   (out_data)
  );

  assign frame_out.out_byte          = out_data.out_byte;
  assign frame_out.out_end           = out_data.out_end;
  assign frame_out.ip_cksum_request  = out_data.ip_cksum_request;
  assign frame_out.udp_cksum_request = out_data.udp_cksum_request;

endmodule

// ----- hdl/phr_cfg.sv -----
// ----------------------------------------------------------------------------
// phr_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module phr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [phr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [phr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output phr_pkg::phr_cfg_t               cfg
);
  import phr_pkg::*;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mac_replace_enable  <= 1'b0;
      cfg.new_dest_mac        <= '0;
      cfg.ip_replace_enable   <= 1'b0;
      cfg.new_dest_ip         <= '0;
      cfg.port_replace_enable <= 1'b0;
      cfg.new_dest_port       <= DEST_PORT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAC_ENABLE:  cfg.mac_replace_enable  <= cfg_data[0];
        CFG_DEST_MAC:    cfg.new_dest_mac        <= cfg_data[47:0];
        CFG_IP_ENABLE:   cfg.ip_replace_enable   <= cfg_data[0];
        CFG_DEST_IP:     cfg.new_dest_ip         <= cfg_data[31:0];
        CFG_PORT_ENABLE: cfg.port_replace_enable <= cfg_data[0];
        CFG_DEST_PORT:   cfg.new_dest_port       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/phr_rewrite.sv -----
// ----------------------------------------------------------------------------
// phr_rewrite
// Per-frame header tracking and byte rewrite for one accepted byte.
// ----------------------------------------------------------------------------
module phr_rewrite #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           frame_byte,
  input  logic                 frame_end,
  input  logic [11:0]          frame_length,
  input  phr_pkg::phr_cfg_t    cfg,
  output phr_pkg::phr_result_t result
);
  import phr_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  // frame state
  logic [POS_W-1:0] byte_position;
  logic             is_ipv4;
  logic [3:0]       header_words;
  logic [7:0]       protocol_byte;
  logic [15:0]      ip_total_length;
  logic [31:0]      source_address;
  logic [31:0]      dest_address_seen;
  logic             ip_flag_seen;
  logic             udp_flag_seen;
  logic [15:0]      pseudo_sum;

  logic             is_ipv4_next;
  logic [3:0]       header_words_next;
  logic [7:0]       protocol_byte_next;
  logic [15:0]      ip_total_length_next;
  logic [31:0]      source_address_next;
  logic [31:0]      dest_address_seen_next;
  logic             ip_flag_seen_next;
  logic             udp_flag_seen_next;

  logic [POS_W-1:0] p;
  logic [6:0]       udp_base;
  logic [POS_W-1:0] udp_port_hi, udp_port_lo, udp_ck_hi, udp_ck_lo;
  logic             ipok, in_dest_ip, udp_ok;
  logic [7:0]       o;

  // pseudo-header sum, settled long before the udp checksum bytes arrive
  logic [15:0] len_field;
  logic [18:0] sum_raw;
  logic [16:0] sum_fold1;
  logic [15:0] sum_fold2;

  assign len_field = ip_total_length - {10'd0, header_words, 2'b00};
  assign sum_raw   = 19'(source_address[31:16]) + 19'(source_address[15:0])
                   + 19'(dest_address_seen[31:16]) + 19'(dest_address_seen[15:0])
                   + 19'(protocol_byte) + 19'(len_field);
  assign sum_fold1 = 17'(sum_raw[18:16]) + 17'(sum_raw[15:0]);
  assign sum_fold2 = 16'(sum_fold1[16]) + sum_fold1[15:0];

  always_ff @(posedge clk) begin
    pseudo_sum <= sum_fold2;
  end

  // byte rewrite and state update
  assign p          = byte_position;
  assign udp_base   = 7'd14 + {1'b0, header_words, 2'b00};
  assign udp_port_hi = POS_W'(udp_base + 7'd2);
  assign udp_port_lo = POS_W'(udp_base + 7'd3);
  assign udp_ck_hi   = POS_W'(udp_base + 7'd6);
  assign udp_ck_lo   = POS_W'(udp_base + 7'd7);
  assign ipok       = is_ipv4 && (p >= POS_W'(14)) && (frame_length >= IP_MIN_FRAME);
  assign in_dest_ip = (p >= POS_W'(30)) && (p <= POS_W'(33));
  assign udp_ok     = cfg.port_replace_enable && (header_words >= IHL_MIN)
                   && (protocol_byte == PROTO_UDP)
                   && (frame_length >= 12'(udp_base + 7'd8));

  always_comb begin
    o                      = frame_byte;
    is_ipv4_next           = is_ipv4;
    header_words_next      = header_words;
    protocol_byte_next     = protocol_byte;
    ip_total_length_next   = ip_total_length;
    source_address_next    = source_address;
    dest_address_seen_next = dest_address_seen;
    ip_flag_seen_next      = ip_flag_seen;
    udp_flag_seen_next     = udp_flag_seen;

    // destination mac
    if (p < POS_W'(6) && cfg.mac_replace_enable) begin
      o = mac_byte(cfg.new_dest_mac, p[2:0]);
    end

    // header capture
    if (p == POS_W'(12)) is_ipv4_next = (frame_byte == ETHERTYPE_HI);
    if (p == POS_W'(13)) is_ipv4_next = is_ipv4 && (frame_byte == ETHERTYPE_LO);
    if (p == POS_W'(14)) header_words_next = 4'(frame_byte & IHL_MASK);
    if (p == POS_W'(16)) ip_total_length_next = {frame_byte, ip_total_length[7:0]};
    if (p == POS_W'(17)) ip_total_length_next = {ip_total_length[15:8], frame_byte};
    if (p == POS_W'(23)) protocol_byte_next = frame_byte;
    if (p >= POS_W'(26) && p <= POS_W'(29)) begin
      source_address_next = {source_address[23:0], frame_byte};
    end

    if (ipok) begin
      // ip destination and header checksum
      if (cfg.ip_replace_enable) begin
        if (p == POS_W'(24) || p == POS_W'(25)) o = 8'd0;
        if (in_dest_ip) o = word_byte(cfg.new_dest_ip, 2'(p - POS_W'(30)));
        if (p == POS_W'(33)) ip_flag_seen_next = 1'b1;
      end
      if (in_dest_ip) dest_address_seen_next = {dest_address_seen[23:0], o};

      // udp destination port and checksum
      if (udp_ok) begin
        if (p == udp_port_hi) o = cfg.new_dest_port[15:8];
        if (p == udp_port_lo) begin
          o = cfg.new_dest_port[7:0];
          udp_flag_seen_next = 1'b1;
        end
        if (p == udp_ck_hi) o = pseudo_sum[15:8];
        if (p == udp_ck_lo) o = pseudo_sum[7:0];
      end
    end
  end

  assign result.out_byte          = o;
  assign result.out_end           = frame_end;
  assign result.ip_cksum_request  = ip_flag_seen_next;
  assign result.udp_cksum_request = udp_flag_seen_next;

  // state registers, cleared after the last byte of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      is_ipv4           <= 1'b0;
      header_words      <= '0;
      protocol_byte     <= '0;
      ip_total_length   <= '0;
      source_address    <= '0;
      dest_address_seen <= '0;
      ip_flag_seen      <= 1'b0;
      udp_flag_seen     <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        byte_position     <= '0;
        is_ipv4           <= 1'b0;
        header_words      <= '0;
        protocol_byte     <= '0;
        ip_total_length   <= '0;
        source_address    <= '0;
        dest_address_seen <= '0;
        ip_flag_seen      <= 1'b0;
        udp_flag_seen     <= 1'b0;
      end else begin
        if (byte_position < POS_MAX) byte_position <= byte_position + POS_W'(1);
        is_ipv4           <= is_ipv4_next;
        header_words      <= header_words_next;
        protocol_byte     <= protocol_byte_next;
        ip_total_length   <= ip_total_length_next;
        source_address    <= source_address_next;
        dest_address_seen <= dest_address_seen_next;
        ip_flag_seen      <= ip_flag_seen_next;
        udp_flag_seen     <= udp_flag_seen_next;
      end
    end
  end

endmodule

// ----- hdl/phr_outbuf.sv -----
// ----------------------------------------------------------------------------
// phr_outbuf
// Output register with a skid stage, two results deep.
// ----------------------------------------------------------------------------
module phr_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  phr_pkg::phr_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output phr_pkg::phr_result_t out_data
);
  import phr_pkg::*;

  logic        main_valid;
  phr_result_t main_data;
  logic        skid_valid;
  phr_result_t skid_data;
  logic        pop;

  assign pop        = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_data <= skid_data;
    end else if (!main_valid || pop) begin
      if (push) main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
